// ===== rtl/core/rrlb_pkg.sv =====
package rrlb_pkg;

  localparam int BUFFER_BYTES_DEF = 1024;
  localparam int HEADER_BYTES_DEF = 2;
  localparam int CAP_W            = 11;
  localparam int CAP_MIN          = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam int RECORDS_OUT_W    = 9;
  localparam int BYTES_OUT_W      = 11;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       end_of_record;
  } in_item_t;

  typedef struct packed {
    logic [7:0]               out_byte;
    logic                     out_valid;
    logic                     out_last;
    logic                     evicted;
    logic                     too_long;
    logic [RECORDS_OUT_W-1:0] records_held;
    logic [BYTES_OUT_W-1:0]   bytes_used;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EV_CHECK,
    S_EV_HREAD,
    S_EV_DROP,
    S_HWRITE,
    S_RD_HREAD,
    S_RD_ISSUE,
    S_RD_TAKE,
    S_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CFG,
    OP_CLEAR,
    OP_DISCARD,
    OP_TOOLONG,
    OP_HSTART,
    OP_HREAD,
    OP_DROP,
    OP_DWRITE,
    OP_HWRITE,
    OP_RISSUE,
    OP_RTAKE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       eor;
    logic       discarding;
    logic       too_long;
    logic       count_zero;
    logic       evict_need;
    logic       hdr_done;
    logic       hw_last;
    logic       out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/record_ring_log_buffer.sv =====
// Byte ring holding variable-length records, each stored as a little-endian length header
// of HEADER_BYTES followed by its payload, dropping whole oldest records when an append
// needs room. One transaction is handled at a time through a single-port byte store, so
// memory accesses are made one at a time: an append evicts each oldest record it must by
// reading its header and dropping it, then writes its byte and, if it ends its record,
// writes its header; a read fetches the header, then one payload byte. Clear, unused
// commands and discarded appends make no access. A configuration write, taken while idle,
// empties the ring. The store is not cleared after reset; only written headers are read.
module record_ring_log_buffer #(
  parameter int BUFFER_BYTES = rrlb_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = rrlb_pkg::HEADER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rrlb_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rrlb_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rrlb_pkg::CAP_W-1:0] cfg_data
);

  rrlb_pkg::dp_op_t     op;
  rrlb_pkg::dp_status_t status;

  rrlb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .status   (status),
    .op       (op)
  );

  rrlb_datapath #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .status   (status),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/rrlb_ram.sv =====
module rrlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rrlb_datapath.sv =====
module rrlb_datapath #(
  parameter int BUFFER_BYTES = rrlb_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = rrlb_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrlb_pkg::dp_op_t              op,
  input  rrlb_pkg::in_item_t            in_data,
  input  logic [rrlb_pkg::CAP_W-1:0]    cfg_data,
  input  logic                          out_ready,
  output rrlb_pkg::dp_status_t          status,
  output logic                          out_valid,
  output rrlb_pkg::out_item_t           out_data
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int CW  = $clog2(BUFFER_BYTES + 1);
  localparam int CW1 = CW + 1;
  localparam int CW2 = CW + 2;
  localparam int HW  = $clog2(HEADER_BYTES + 1);
  localparam int LW  = (HEADER_BYTES * 8 > CW) ? HEADER_BYTES * 8 : CW;
  localparam int KW  = (CW > rrlb_pkg::CAP_W) ? CW : rrlb_pkg::CAP_W;
  localparam logic [CW1-1:0] HMAX = (HEADER_BYTES * 8 >= CW1) ? '1 :
                                    (CW1'(1) << (HEADER_BYTES * 8)) - CW1'(1);

  function automatic logic [AW-1:0] wrap(input logic [CW1-1:0] s,
                                         input logic [CW-1:0] cap);
    logic [CW1-1:0] r;
    r = (s >= CW1'(cap)) ? s - CW1'(cap) : s;
    return AW'(r);
  endfunction

  function automatic logic [CW-1:0] clamp(input logic [rrlb_pkg::CAP_W-1:0] v);
    logic [KW-1:0] w;
    w = KW'(v);
    if (w < KW'(rrlb_pkg::CAP_MIN)) begin
      w = KW'(rrlb_pkg::CAP_MIN);
    end else if (w > KW'(BUFFER_BYTES)) begin
      w = KW'(BUFFER_BYTES);
    end
    return CW'(w);
  endfunction

  logic [CW-1:0]       cap_r, cap_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       committed_r, committed_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       asm_r, asm_nxt;
  logic                disc_r, disc_nxt;
  logic [CW-1:0]       rdoff_r, rdoff_nxt;
  rrlb_pkg::in_item_t  item_r, item_nxt;
  logic [LW-1:0]       hdr_r, hdr_nxt;
  logic [HW-1:0]       hidx_r, hidx_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic                evict_f_r, evict_f_nxt;
  logic                long_f_r, long_f_nxt;
  logic                valid_f_r, valid_f_nxt;
  logic                last_f_r, last_f_nxt;
  logic [7:0]          byte_f_r, byte_f_nxt;
  logic                out_valid_r, out_valid_nxt;
  rrlb_pkg::out_item_t out_data_r, out_data_nxt;

  logic [CW-1:0]  len;
  logic [CW1-1:0] asm1, need;
  logic [CW2-1:0] sum_c;
  logic           over_c;
  logic [CW-1:0]  comm_eff;
  logic [CW1-1:0] n_full;
  logic [CW-1:0]  n_c;
  logic [CW-1:0]  off_c;
  logic [HW-1:0]  hidx_m1;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [7:0]     mem_wdata;
  logic [7:0]     mem_rdata;

  rrlb_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_comb begin
    len      = hdr_r[CW-1:0];
    asm1     = CW1'(asm_r) + CW1'(1);
    need     = CW1'(HEADER_BYTES) + asm1;
    sum_c    = CW2'(committed_r) + CW2'(need);
    over_c   = sum_c > CW2'(cap_r);
    comm_eff = over_c ? CW'(CW1'(cap_r) - need) : committed_r;
    n_full   = CW1'(HEADER_BYTES) + CW1'(len);
    n_c      = (n_full > CW1'(committed_r)) ? committed_r : CW'(n_full);
    off_c    = (rdoff_r >= len) ? '0 : rdoff_r;
    hidx_m1  = hidx_r - HW'(1);
  end

  always_comb begin
    status.cmd        = item_r.cmd;
    status.eor        = item_r.end_of_record;
    status.discarding = disc_r;
    status.too_long   = (need > CW1'(cap_r)) || (asm1 > HMAX);
    status.count_zero = (count_r == '0);
    status.evict_need = (count_r != '0) && over_c;
    status.hdr_done   = (hidx_r == HW'(HEADER_BYTES));
    status.hw_last    = (hidx_r == HW'(HEADER_BYTES - 1));
    status.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    cap_nxt       = cap_r;
    head_nxt      = head_r;
    committed_nxt = committed_r;
    count_nxt     = count_r;
    asm_nxt       = asm_r;
    disc_nxt      = disc_r;
    rdoff_nxt     = rdoff_r;
    item_nxt      = item_r;
    hdr_nxt       = hdr_r;
    hidx_nxt      = hidx_r;
    ptr_nxt       = ptr_r;
    evict_f_nxt   = evict_f_r;
    long_f_nxt    = long_f_r;
    valid_f_nxt   = valid_f_r;
    last_f_nxt    = last_f_r;
    byte_f_nxt    = byte_f_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_addr      = ptr_r;
    mem_wdata     = hdr_r[8*hidx_r +: 8];

    unique case (op)
      rrlb_pkg::OP_NONE: begin
      end
      rrlb_pkg::OP_ACCEPT: begin
        item_nxt    = in_data;
        evict_f_nxt = 1'b0;
        long_f_nxt  = 1'b0;
        valid_f_nxt = 1'b0;
        last_f_nxt  = 1'b0;
        byte_f_nxt  = '0;
      end
      rrlb_pkg::OP_CFG, rrlb_pkg::OP_CLEAR: begin
        if (op == rrlb_pkg::OP_CFG) begin
          cap_nxt = clamp(cfg_data);
        end
        head_nxt      = '0;
        committed_nxt = '0;
        count_nxt     = '0;
        asm_nxt       = '0;
        disc_nxt      = 1'b0;
        rdoff_nxt     = '0;
      end
      rrlb_pkg::OP_DISCARD: begin
        long_f_nxt = 1'b1;
        if (item_r.end_of_record) begin
          disc_nxt = 1'b0;
        end
      end
      rrlb_pkg::OP_TOOLONG: begin
        long_f_nxt = 1'b1;
        asm_nxt    = '0;
        disc_nxt   = !item_r.end_of_record;
      end
      rrlb_pkg::OP_HSTART: begin
        ptr_nxt  = head_r;
        hidx_nxt = '0;
        hdr_nxt  = '0;
      end
      rrlb_pkg::OP_HREAD: begin
        if (hidx_r != HW'(HEADER_BYTES)) begin
          ptr_nxt = wrap(CW1'(ptr_r) + CW1'(1), cap_r);
        end
        if (hidx_r != '0) begin
          hdr_nxt[8*hidx_m1 +: 8] = mem_rdata;
        end
        hidx_nxt = hidx_r + HW'(1);
      end
      rrlb_pkg::OP_DROP: begin
        head_nxt      = wrap(CW1'(head_r) + CW1'(n_c), cap_r);
        committed_nxt = committed_r - n_c;
        count_nxt     = count_r - CW'(1);
        rdoff_nxt     = '0;
        evict_f_nxt   = 1'b1;
      end
      rrlb_pkg::OP_DWRITE: begin
        mem_we        = 1'b1;
        mem_wdata     = item_r.data_byte;
        mem_addr      = wrap(CW1'(head_r) + CW1'(comm_eff) + CW1'(HEADER_BYTES)
                             + CW1'(asm_r), cap_r);
        committed_nxt = comm_eff;
        asm_nxt       = CW'(asm1);
        if (item_r.end_of_record) begin
          ptr_nxt       = wrap(CW1'(head_r) + CW1'(comm_eff), cap_r);
          hidx_nxt      = '0;
          hdr_nxt       = LW'(asm1);
          committed_nxt = CW'(CW1'(comm_eff) + need);
          count_nxt     = count_r + CW'(1);
          asm_nxt       = '0;
        end
      end
      rrlb_pkg::OP_HWRITE: begin
        mem_we   = 1'b1;
        ptr_nxt  = wrap(CW1'(ptr_r) + CW1'(1), cap_r);
        hidx_nxt = hidx_r + HW'(1);
      end
      rrlb_pkg::OP_RISSUE: begin
        mem_addr  = wrap(CW1'(head_r) + CW1'(HEADER_BYTES) + CW1'(off_c), cap_r);
        rdoff_nxt = off_c + CW'(1);
      end
      rrlb_pkg::OP_RTAKE: begin
        valid_f_nxt = 1'b1;
        byte_f_nxt  = mem_rdata;
        if (rdoff_r >= len) begin
          last_f_nxt    = 1'b1;
          head_nxt      = wrap(CW1'(head_r) + CW1'(n_c), cap_r);
          committed_nxt = committed_r - n_c;
          count_nxt     = count_r - CW'(1);
          rdoff_nxt     = '0;
        end
      end
      rrlb_pkg::OP_EMIT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.out_byte     = byte_f_r;
        out_data_nxt.out_valid    = valid_f_r;
        out_data_nxt.out_last     = last_f_r;
        out_data_nxt.evicted      = evict_f_r;
        out_data_nxt.too_long     = long_f_r;
        out_data_nxt.records_held = rrlb_pkg::RECORDS_OUT_W'(count_r);
        out_data_nxt.bytes_used   = rrlb_pkg::BYTES_OUT_W'(committed_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= clamp(rrlb_pkg::CAP_RESET);
      head_r      <= '0;
      committed_r <= '0;
      count_r     <= '0;
      asm_r       <= '0;
      disc_r      <= 1'b0;
      rdoff_r     <= '0;
      hidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      committed_r <= committed_nxt;
      count_r     <= count_nxt;
      asm_r       <= asm_nxt;
      disc_r      <= disc_nxt;
      rdoff_r     <= rdoff_nxt;
      hidx_r      <= hidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    hdr_r      <= hdr_nxt;
    ptr_r      <= ptr_nxt;
    evict_f_r  <= evict_f_nxt;
    long_f_r   <= long_f_nxt;
    valid_f_r  <= valid_f_nxt;
    last_f_r   <= last_f_nxt;
    byte_f_r   <= byte_f_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_committed_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= cap_r) else $error("Committed bytes exceed the ring size.");
  a_head_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    CW1'(head_r) < CW1'(cap_r)) else $error("Head pointer lies outside the ring.");
  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> committed_r == '0)
    else $error("An empty ring still holds committed bytes.");
  a_asm_fits: assert property (@(posedge clk) disable iff (!rst_n)
    CW1'(asm_r) + CW1'(HEADER_BYTES) <= CW1'(cap_r))
    else $error("The record being assembled does not fit the ring.");
`endif

endmodule

// ===== rtl/core/rrlb_ctrl.sv =====
module rrlb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  rrlb_pkg::dp_status_t status,
  output rrlb_pkg::dp_op_t     op
);

  rrlb_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrlb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = rrlb_pkg::OP_NONE;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;

    unique case (state_r)
      rrlb_pkg::S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          op = rrlb_pkg::OP_CFG;
        end else if (in_valid) begin
          op        = rrlb_pkg::OP_ACCEPT;
          state_nxt = rrlb_pkg::S_DECODE;
        end
      end
      rrlb_pkg::S_DECODE: begin
        state_nxt = rrlb_pkg::S_FINISH;
        priority case (status.cmd)
          rrlb_pkg::CMD_APPEND: begin
            if (status.discarding) begin
              op = rrlb_pkg::OP_DISCARD;
            end else if (status.too_long) begin
              op = rrlb_pkg::OP_TOOLONG;
            end else begin
              state_nxt = rrlb_pkg::S_EV_CHECK;
            end
          end
          rrlb_pkg::CMD_READ: begin
            if (!status.count_zero) begin
              op        = rrlb_pkg::OP_HSTART;
              state_nxt = rrlb_pkg::S_RD_HREAD;
            end
          end
          rrlb_pkg::CMD_CLEAR: begin
            op = rrlb_pkg::OP_CLEAR;
          end
          default: begin
          end
        endcase
      end
      rrlb_pkg::S_EV_CHECK: begin
        if (status.evict_need) begin
          op        = rrlb_pkg::OP_HSTART;
          state_nxt = rrlb_pkg::S_EV_HREAD;
        end else begin
          op        = rrlb_pkg::OP_DWRITE;
          state_nxt = status.eor ? rrlb_pkg::S_HWRITE : rrlb_pkg::S_FINISH;
        end
      end
      rrlb_pkg::S_EV_HREAD: begin
        op = rrlb_pkg::OP_HREAD;
        if (status.hdr_done) begin
          state_nxt = rrlb_pkg::S_EV_DROP;
        end
      end
      rrlb_pkg::S_EV_DROP: begin
        op        = rrlb_pkg::OP_DROP;
        state_nxt = rrlb_pkg::S_EV_CHECK;
      end
      rrlb_pkg::S_HWRITE: begin
        op = rrlb_pkg::OP_HWRITE;
        if (status.hw_last) begin
          state_nxt = rrlb_pkg::S_FINISH;
        end
      end
      rrlb_pkg::S_RD_HREAD: begin
        op = rrlb_pkg::OP_HREAD;
        if (status.hdr_done) begin
          state_nxt = rrlb_pkg::S_RD_ISSUE;
        end
      end
      rrlb_pkg::S_RD_ISSUE: begin
        op        = rrlb_pkg::OP_RISSUE;
        state_nxt = rrlb_pkg::S_RD_TAKE;
      end
      rrlb_pkg::S_RD_TAKE: begin
        op        = rrlb_pkg::OP_RTAKE;
        state_nxt = rrlb_pkg::S_FINISH;
      end
      rrlb_pkg::S_FINISH: begin
        if (status.out_free) begin
          op        = rrlb_pkg::OP_EMIT;
          state_nxt = rrlb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrlb_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> state_r == rrlb_pkg::S_IDLE)
    else $error("A transaction was accepted outside the idle state.");
  a_no_dual_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && cfg_valid && cfg_ready))
    else $error("Input and configuration transactions were accepted together.");
  a_emit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op == rrlb_pkg::OP_EMIT |=> state_r == rrlb_pkg::S_IDLE)
    else $error("The controller did not return to idle after emitting a result.");
`endif

endmodule
